/* design/x86mov_pkg.sv */
// Shared types and constants for the x86 MOV instruction decoder.
// Used by every module of the block; depends on nothing else.
package x86mov_pkg;

  // One code byte of the instruction buffer.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_item_t;

  // One decode result, one per buffer.
  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         length;
    logic [1:0]         form;
    logic [2:0]         dest_reg;
    logic [2:0]         src_reg;
    logic               size_16;
    logic signed [31:0] value;
    logic               lock;
    logic               rep;
    logic               repne;
    logic [2:0]         segment;
    logic               address_16;
  } out_item_t;

  // Decode phase within one buffer.
  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_MODRM,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_UNSUPP    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // Instruction form codes.
  localparam logic [1:0] FORM_RM_REG  = 2'd0;
  localparam logic [1:0] FORM_REG_IMM = 2'd1;
  localparam logic [1:0] FORM_REG_REG = 2'd2;
  localparam logic [1:0] FORM_REG_MEM = 2'd3;

  // Segment override codes.
  localparam logic [2:0] SEG_NONE = 3'd0;
  localparam logic [2:0] SEG_ES   = 3'd1;
  localparam logic [2:0] SEG_CS   = 3'd2;
  localparam logic [2:0] SEG_SS   = 3'd3;
  localparam logic [2:0] SEG_DS   = 3'd4;
  localparam logic [2:0] SEG_FS   = 3'd5;
  localparam logic [2:0] SEG_GS   = 3'd6;

  // Prefix bytes.
  localparam logic [7:0] PFX_LOCK   = 8'hF0;
  localparam logic [7:0] PFX_REPNE  = 8'hF2;
  localparam logic [7:0] PFX_REP    = 8'hF3;
  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_CS     = 8'h2E;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_DS     = 8'h3E;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;
  localparam logic [7:0] PFX_OP16   = 8'h66;
  localparam logic [7:0] PFX_ADDR16 = 8'h67;

  // Opcodes of the supported MOV forms.
  localparam logic [7:0] OP_MOV_RM_REG = 8'h89;
  localparam logic [7:0] OP_MOV_REG_RM = 8'h8B;
  localparam logic [7:0] OP_MOV_IMM    = 8'hB8;
  localparam logic [7:0] OP_IMM_MASK   = 8'hF8;

  // ModRM mod field values.
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_REG    = 2'd3;

endpackage

/* design/x86_mov_instruction_decoder.sv */
// Decoder for three x86 MOV forms, fed one code byte request per cycle while the result register has space.
// Top level; depends on x86mov_pkg, x86mov_in_reg, x86mov_decode, x86mov_out_reg.
//
// The byte channel (byte_valid, byte_ready, byte_data) carries the code bytes
// of one buffer, the final one marked by last_byte. The result channel
// (result_valid, result_ready, result_data) carries exactly one result per
// buffer: status, length, form, registers, value and the prefixes seen.
// A byte is held in the input register, decoded combinationally against the
// buffer state, and its result, if any, is loaded into the result register
// once that register has space. One byte is taken every cycle while the
// result register has space; the only loop is the per-byte state update
// between the two registers. Bytes after the instruction ends are swallowed
// until the final byte, which returns the buffer state to its reset value.
// Reset empties both registers and clears the buffer state. While a result
// waits unread, the byte holding the input register is not decoded and
// byte_ready falls once that register is full; nothing is dropped.
module x86_mov_instruction_decoder #(
  parameter int MAX_INSN_LENGTH = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  x86mov_pkg::in_item_t  byte_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output x86mov_pkg::out_item_t result_data
);

  logic                  held_valid;
  x86mov_pkg::in_item_t  held_data;
  logic                  step;
  logic                  space;
  logic                  dec_emit;
  x86mov_pkg::out_item_t dec_res;

  // A held byte is decoded when the result register can take a result.
  assign step = held_valid && space;

  x86mov_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .step       (step),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  x86mov_decode #(
    .MAX_INSN_LENGTH (MAX_INSN_LENGTH)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (held_data),
    .emit    (dec_emit),
    .res     (dec_res)
  );

  x86mov_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && dec_emit),
    .load_data    (dec_res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  // A decoded result always lands in the result register.
  assert property (@(posedge clk) disable iff (rst)
    step && dec_emit |=> result_valid)
    else $error("decoded result was not registered");

  // A waiting result is never overwritten by a new decode.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !step)
    else $error("byte decoded while a result was waiting");

  // A too-long result always reports the length limit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status == x86mov_pkg::ST_TOO_LONG
      |-> result_data.length == 4'(MAX_INSN_LENGTH))
    else $error("too-long result with wrong length");

  // A stalled result stays offered with its payload unchanged.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("waiting result changed or was withdrawn");

endmodule

/* design/x86mov_in_reg.sv */
// Input register of the MOV decoder: holds one code byte request.
// Depends on x86mov_pkg for the byte type.
module x86mov_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  x86mov_pkg::in_item_t byte_data,
  input  logic                 step,
  output logic                 held_valid,
  output x86mov_pkg::in_item_t held_data
);

  // Room for a new byte when empty or when the held byte is consumed now.
  assign byte_ready = !held_valid || step;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      held_data <= byte_data;
    end
  end

endmodule

/* design/x86mov_decode.sv */
// Per-byte decode state and next-state logic of the MOV decoder.
// Depends on x86mov_pkg for types, phases and byte constants.
module x86mov_decode #(
  parameter int MAX_INSN_LENGTH = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  x86mov_pkg::in_item_t  byte_in,
  output logic                  emit,
  output x86mov_pkg::out_item_t res
);

  localparam int CW = $clog2(MAX_INSN_LENGTH + 1);

  // Buffer state.
  x86mov_pkg::phase_t phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic          pf_lock, pf_lock_next;
  logic          pf_rep, pf_rep_next;
  logic          pf_repne, pf_repne_next;
  logic          pf_op16, pf_op16_next;
  logic          pf_addr16, pf_addr16_next;
  logic [2:0]    pf_segment, pf_segment_next;
  logic [7:0]    opcode_reg, opcode_reg_next;
  logic [7:0]    modrm_reg, modrm_reg_next;
  logic [31:0]   value_accum, value_accum_next;
  logic [2:0]    value_left, value_left_next;

  // Result fields before assembly.
  logic [1:0]  r_status;
  logic [3:0]  r_length;
  logic [1:0]  r_form;
  logic [2:0]  r_dest;
  logic [2:0]  r_src;
  logic        r_size16;
  logic [31:0] r_value;

  // Byte slices and value assembly helpers.
  logic [7:0]  b;
  logic [1:0]  b_mod;
  logic [1:0]  m_mod;
  logic        disp8;
  logic [2:0]  value_total;
  logic [1:0]  value_idx;
  logic [31:0] accum_new;
  logic [2:0]  left_new;
  logic [31:0] disp_value;
  logic [CW-1:0] count_inc;

  assign b           = byte_in.code_byte;
  assign b_mod       = b[7:6];
  assign m_mod       = modrm_reg[7:6];
  assign disp8       = (opcode_reg == x86mov_pkg::OP_MOV_REG_RM) &&
                       (m_mod == x86mov_pkg::MOD_DISP8);
  assign value_total = disp8 ? 3'd1 : 3'd4;
  assign value_idx   = 2'(value_total - value_left);
  assign accum_new   = value_accum | ({24'd0, b} << {value_idx, 3'b000});
  assign left_new    = value_left - 3'd1;
  assign disp_value  = (disp8 && accum_new[7]) ? (accum_new | 32'hFFFF_FF00) : accum_new;
  assign count_inc   = byte_count + CW'(1);

  // Next state and result for the byte in hand.
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    pf_lock_next     = pf_lock;
    pf_rep_next      = pf_rep;
    pf_repne_next    = pf_repne;
    pf_op16_next     = pf_op16;
    pf_addr16_next   = pf_addr16;
    pf_segment_next  = pf_segment;
    opcode_reg_next  = opcode_reg;
    modrm_reg_next   = modrm_reg;
    value_accum_next = value_accum;
    value_left_next  = value_left;
    emit     = 1'b0;
    r_status = x86mov_pkg::ST_OK;
    r_length = 4'd0;
    r_form   = x86mov_pkg::FORM_RM_REG;
    r_dest   = 3'd0;
    r_src    = 3'd0;
    r_size16 = 1'b0;
    r_value  = 32'd0;

    if (phase != x86mov_pkg::PH_DONE) begin
      if (byte_count >= CW'(MAX_INSN_LENGTH)) begin
        // Length limit reached with the instruction still open.
        emit     = 1'b1;
        r_status = x86mov_pkg::ST_TOO_LONG;
        r_length = 4'(MAX_INSN_LENGTH);
      end else begin
        byte_count_next = count_inc;
        r_length        = count_inc[3:0];
        case (phase)
          x86mov_pkg::PH_PREFIX: begin
            case (b)
              x86mov_pkg::PFX_LOCK:   pf_lock_next = 1'b1;
              x86mov_pkg::PFX_REPNE:  pf_repne_next = 1'b1;
              x86mov_pkg::PFX_REP:    pf_rep_next = 1'b1;
              x86mov_pkg::PFX_ES:     pf_segment_next = x86mov_pkg::SEG_ES;
              x86mov_pkg::PFX_CS:     pf_segment_next = x86mov_pkg::SEG_CS;
              x86mov_pkg::PFX_SS:     pf_segment_next = x86mov_pkg::SEG_SS;
              x86mov_pkg::PFX_DS:     pf_segment_next = x86mov_pkg::SEG_DS;
              x86mov_pkg::PFX_FS:     pf_segment_next = x86mov_pkg::SEG_FS;
              x86mov_pkg::PFX_GS:     pf_segment_next = x86mov_pkg::SEG_GS;
              x86mov_pkg::PFX_OP16:   pf_op16_next = 1'b1;
              x86mov_pkg::PFX_ADDR16: pf_addr16_next = 1'b1;
              default: begin
                opcode_reg_next = b;
                if (b == x86mov_pkg::OP_MOV_RM_REG || b == x86mov_pkg::OP_MOV_REG_RM) begin
                  phase_next = x86mov_pkg::PH_MODRM;
                end else if ((b & x86mov_pkg::OP_IMM_MASK) == x86mov_pkg::OP_MOV_IMM) begin
                  value_accum_next = 32'd0;
                  value_left_next  = 3'd4;
                  phase_next       = x86mov_pkg::PH_VALUE;
                end else begin
                  emit     = 1'b1;
                  r_status = x86mov_pkg::ST_UNSUPP;
                end
              end
            endcase
          end
          x86mov_pkg::PH_MODRM: begin
            modrm_reg_next = b;
            if (opcode_reg == x86mov_pkg::OP_MOV_RM_REG) begin
              emit = 1'b1;
              if (b_mod == x86mov_pkg::MOD_REG) begin
                r_dest = b[2:0];
                r_src  = b[5:3];
              end else begin
                r_status = x86mov_pkg::ST_UNSUPP;
              end
            end else if (b_mod == x86mov_pkg::MOD_REG || b_mod == x86mov_pkg::MOD_NODISP) begin
              emit     = 1'b1;
              r_form   = (b_mod == x86mov_pkg::MOD_REG) ? x86mov_pkg::FORM_REG_REG
                                                        : x86mov_pkg::FORM_REG_MEM;
              r_dest   = b[5:3];
              r_src    = b[2:0];
              r_size16 = pf_op16;
            end else begin
              value_accum_next = 32'd0;
              value_left_next  = (b_mod == x86mov_pkg::MOD_DISP8) ? 3'd1 : 3'd4;
              phase_next       = x86mov_pkg::PH_VALUE;
            end
          end
          x86mov_pkg::PH_VALUE: begin
            // Little-endian value bytes; disp8 is sign-extended at the end.
            value_accum_next = accum_new;
            value_left_next  = left_new;
            if (left_new == 3'd0) begin
              emit = 1'b1;
              if (opcode_reg != x86mov_pkg::OP_MOV_REG_RM) begin
                r_form  = x86mov_pkg::FORM_REG_IMM;
                r_dest  = opcode_reg[2:0];
                r_value = accum_new;
              end else begin
                value_accum_next = disp_value;
                r_form   = (m_mod == x86mov_pkg::MOD_REG) ? x86mov_pkg::FORM_REG_REG
                                                          : x86mov_pkg::FORM_REG_MEM;
                r_dest   = modrm_reg[5:3];
                r_src    = modrm_reg[2:0];
                r_size16 = pf_op16;
                r_value  = disp_value;
              end
            end
          end
          default: ;
        endcase
      end
      if (emit) begin
        phase_next = x86mov_pkg::PH_DONE;
      end
    end

    // The final byte closes the buffer, reporting truncation if nothing went out.
    if (byte_in.last_byte) begin
      if (!emit && phase != x86mov_pkg::PH_DONE) begin
        emit     = 1'b1;
        r_status = x86mov_pkg::ST_TRUNCATED;
        r_length = byte_count_next[3:0];
        r_form   = x86mov_pkg::FORM_RM_REG;
        r_dest   = 3'd0;
        r_src    = 3'd0;
        r_size16 = 1'b0;
        r_value  = 32'd0;
      end
    end
  end

  // Result word; the prefix fields include this byte's prefix.
  always_comb begin
    res.status     = r_status;
    res.length     = r_length;
    res.form       = r_form;
    res.dest_reg   = r_dest;
    res.src_reg    = r_src;
    res.size_16    = r_size16;
    res.value      = r_value;
    res.lock       = pf_lock_next;
    res.rep        = pf_rep_next;
    res.repne      = pf_repne_next;
    res.segment    = pf_segment_next;
    res.address_16 = pf_addr16_next;
  end

  // State registers; everything returns to reset after the final byte.
  always_ff @(posedge clk) begin
    if (rst || (step && byte_in.last_byte)) begin
      phase       <= x86mov_pkg::PH_PREFIX;
      byte_count  <= '0;
      pf_lock     <= 1'b0;
      pf_rep      <= 1'b0;
      pf_repne    <= 1'b0;
      pf_op16     <= 1'b0;
      pf_addr16   <= 1'b0;
      pf_segment  <= x86mov_pkg::SEG_NONE;
      opcode_reg  <= 8'd0;
      modrm_reg   <= 8'd0;
      value_accum <= 32'd0;
      value_left  <= 3'd0;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      pf_lock     <= pf_lock_next;
      pf_rep      <= pf_rep_next;
      pf_repne    <= pf_repne_next;
      pf_op16     <= pf_op16_next;
      pf_addr16   <= pf_addr16_next;
      pf_segment  <= pf_segment_next;
      opcode_reg  <= opcode_reg_next;
      modrm_reg   <= modrm_reg_next;
      value_accum <= value_accum_next;
      value_left  <= value_left_next;
    end
  end

endmodule

/* design/x86mov_out_reg.sv */
// Result register of the MOV decoder: holds one finished result.
// Depends on x86mov_pkg for the result type.
module x86mov_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  x86mov_pkg::out_item_t load_data,
  output logic                  space,
  output logic                  result_valid,
  input  logic                  result_ready,
  output x86mov_pkg::out_item_t result_data
);

  // A new result may be written when empty or when the waiting one leaves now.
  assign space = !result_valid || result_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= load;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

endmodule

/* test/x86mov_decode_checker.sv */
// Checker for the x86 MOV decoder: watches both channels, predicts each decode and compares.
// Depends on x86mov_pkg for the request and result types and the decode constants.
`timescale 1ns / 100ps

module x86mov_decode_checker #(
  parameter int MAX_INSN_LENGTH = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic                  byte_ready,
  input  x86mov_pkg::in_item_t  byte_data,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  x86mov_pkg::out_item_t result_data,
  output int                    error_count,
  output int                    outstanding
);

  // Decoder state for the buffer in progress.
  x86mov_pkg::phase_t dec_phase;
  int          byte_count;
  logic        pf_lock, pf_rep, pf_repne, pf_op16, pf_addr16;
  logic [2:0]  pf_segment;
  logic [7:0]  opcode_q;
  logic [7:0]  modrm_q;
  logic [31:0] value_accum;
  int          value_left;
  logic        result_sent;

  // Decodes predicted but not yet seen on the result channel.
  x86mov_pkg::out_item_t predicted_decodes[$];
  x86mov_pkg::out_item_t head;

  // Return the buffer state to its value at reset.
  task automatic clear_decode_state();
    dec_phase   = x86mov_pkg::PH_PREFIX;
    byte_count  = 0;
    pf_lock     = 1'b0;
    pf_rep      = 1'b0;
    pf_repne    = 1'b0;
    pf_op16     = 1'b0;
    pf_addr16   = 1'b0;
    pf_segment  = x86mov_pkg::SEG_NONE;
    opcode_q    = '0;
    modrm_q     = '0;
    value_accum = '0;
    value_left  = 0;
    result_sent = 1'b0;
  endtask

  // Record one decode result together with the prefixes seen so far.
  task automatic post_decode(input logic [1:0] status, input logic [3:0] len,
                             input logic [1:0] form, input logic [2:0] dest,
                             input logic [2:0] src, input logic s16,
                             input logic [31:0] value);
    x86mov_pkg::out_item_t r;
    r.status     = status;
    r.length     = len;
    r.form       = form;
    r.dest_reg   = dest;
    r.src_reg    = src;
    r.size_16    = s16;
    r.value      = value;
    r.lock       = pf_lock;
    r.rep        = pf_rep;
    r.repne      = pf_repne;
    r.segment    = pf_segment;
    r.address_16 = pf_addr16;
    predicted_decodes.push_back(r);
    result_sent = 1'b1;
    dec_phase   = x86mov_pkg::PH_DONE;
  endtask

  // A finished 8B load: register or memory source depending on mod.
  task automatic finish_load(input logic [31:0] value);
    post_decode(x86mov_pkg::ST_OK, byte_count[3:0],
                (modrm_q[7:6] == x86mov_pkg::MOD_REG) ? x86mov_pkg::FORM_REG_REG
                                                      : x86mov_pkg::FORM_REG_MEM,
                modrm_q[5:3], modrm_q[2:0], pf_op16, value);
  endtask

  // Advance the decode by one accepted code byte.
  task automatic decode_code_byte(input logic [7:0] b, input logic last);
    logic disp8;
    int   total;
    int   idx;
    if (dec_phase != x86mov_pkg::PH_DONE) begin
      if (byte_count >= MAX_INSN_LENGTH) begin
        post_decode(x86mov_pkg::ST_TOO_LONG, 4'(MAX_INSN_LENGTH),
                    x86mov_pkg::FORM_RM_REG, '0, '0, 1'b0, '0);
      end else begin
        byte_count++;
        case (dec_phase)
          x86mov_pkg::PH_PREFIX: begin
            case (b)
              x86mov_pkg::PFX_LOCK:   pf_lock = 1'b1;
              x86mov_pkg::PFX_REPNE:  pf_repne = 1'b1;
              x86mov_pkg::PFX_REP:    pf_rep = 1'b1;
              x86mov_pkg::PFX_ES:     pf_segment = x86mov_pkg::SEG_ES;
              x86mov_pkg::PFX_CS:     pf_segment = x86mov_pkg::SEG_CS;
              x86mov_pkg::PFX_SS:     pf_segment = x86mov_pkg::SEG_SS;
              x86mov_pkg::PFX_DS:     pf_segment = x86mov_pkg::SEG_DS;
              x86mov_pkg::PFX_FS:     pf_segment = x86mov_pkg::SEG_FS;
              x86mov_pkg::PFX_GS:     pf_segment = x86mov_pkg::SEG_GS;
              x86mov_pkg::PFX_OP16:   pf_op16 = 1'b1;
              x86mov_pkg::PFX_ADDR16: pf_addr16 = 1'b1;
              default: begin
                opcode_q = b;
                if (b == x86mov_pkg::OP_MOV_RM_REG || b == x86mov_pkg::OP_MOV_REG_RM) begin
                  dec_phase = x86mov_pkg::PH_MODRM;
                end else if ((b & x86mov_pkg::OP_IMM_MASK) == x86mov_pkg::OP_MOV_IMM) begin
                  value_accum = '0;
                  value_left  = 4;
                  dec_phase   = x86mov_pkg::PH_VALUE;
                end else begin
                  post_decode(x86mov_pkg::ST_UNSUPP, byte_count[3:0],
                              x86mov_pkg::FORM_RM_REG, '0, '0, 1'b0, '0);
                end
              end
            endcase
          end
          x86mov_pkg::PH_MODRM: begin
            modrm_q = b;
            if (opcode_q == x86mov_pkg::OP_MOV_RM_REG) begin
              // Only the register form of the store is supported.
              if (b[7:6] == x86mov_pkg::MOD_REG)
                post_decode(x86mov_pkg::ST_OK, byte_count[3:0], x86mov_pkg::FORM_RM_REG,
                            b[2:0], b[5:3], 1'b0, '0);
              else
                post_decode(x86mov_pkg::ST_UNSUPP, byte_count[3:0],
                            x86mov_pkg::FORM_RM_REG, '0, '0, 1'b0, '0);
            end else if (b[7:6] == x86mov_pkg::MOD_REG ||
                         b[7:6] == x86mov_pkg::MOD_NODISP) begin
              finish_load('0);
            end else begin
              value_accum = '0;
              value_left  = (b[7:6] == x86mov_pkg::MOD_DISP8) ? 1 : 4;
              dec_phase   = x86mov_pkg::PH_VALUE;
            end
          end
          default: begin
            // Little-endian immediate or displacement bytes.
            disp8 = (opcode_q == x86mov_pkg::OP_MOV_REG_RM) &&
                    (modrm_q[7:6] == x86mov_pkg::MOD_DISP8);
            total = disp8 ? 1 : 4;
            idx   = (total - value_left) & 3;
            value_accum = value_accum | (32'(b) << (8 * idx));
            value_left--;
            if (value_left == 0) begin
              if (opcode_q != x86mov_pkg::OP_MOV_REG_RM) begin
                post_decode(x86mov_pkg::ST_OK, byte_count[3:0], x86mov_pkg::FORM_REG_IMM,
                            opcode_q[2:0], '0, 1'b0, value_accum);
              end else begin
                if (disp8 && value_accum[7])
                  value_accum = value_accum | 32'hFFFF_FF00;
                finish_load(value_accum);
              end
            end
          end
        endcase
      end
    end
    // The final byte closes the buffer, reporting truncation if nothing came out.
    if (last) begin
      if (!result_sent)
        post_decode(x86mov_pkg::ST_TRUNCATED, byte_count[3:0], x86mov_pkg::FORM_RM_REG,
                    '0, '0, 1'b0, '0);
      clear_decode_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Sample both channels at each edge; predictions go in before comparisons.
  always @(posedge clk) begin
    if (rst) begin
      clear_decode_state();
      predicted_decodes.delete();
      error_count = 0;
    end else begin
      if (byte_valid && byte_ready)
        decode_code_byte(byte_data.code_byte, byte_data.last_byte);
      if (result_valid && result_ready) begin
        if (predicted_decodes.size() == 0) begin
          $error("result request arrived with no decode awaited");
          error_count++;
        end else begin
          head = predicted_decodes.pop_front();
          check_field("status", head.status, result_data.status);
          check_field("length", head.length, result_data.length);
          check_field("form", head.form, result_data.form);
          check_field("dest_reg", head.dest_reg, result_data.dest_reg);
          check_field("src_reg", head.src_reg, result_data.src_reg);
          check_field("size_16", head.size_16, result_data.size_16);
          check_field("value", head.value, result_data.value);
          check_field("lock", head.lock, result_data.lock);
          check_field("rep", head.rep, result_data.rep);
          check_field("repne", head.repne, result_data.repne);
          check_field("segment", head.segment, result_data.segment);
          check_field("address_16", head.address_16, result_data.address_16);
        end
      end
    end
    outstanding = predicted_decodes.size();
  end

endmodule

/* test/x86_mov_instruction_decoder_tb.sv */
// Testbench top for the x86 MOV decoder: clock, reset, code-byte stimulus and verdict.
// Depends on x86mov_pkg, the decoder RTL and x86mov_decode_checker.
`timescale 1ns / 100ps

module x86_mov_instruction_decoder_tb;

  localparam int         STALL_LIMIT    = 4000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 8;
  localparam logic [7:0] OP_ESCAPE      = 8'h0F;
  localparam logic [7:0] OP_MOV_IMM_EDI = x86mov_pkg::OP_MOV_IMM | 8'h07;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  x86mov_pkg::in_item_t  byte_data = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  x86mov_pkg::out_item_t result_data;

  int        error_count;
  int        outstanding;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_req = 1'b0;
  int        hold_count = 0;
  int        idle_cycles = 0;
  int        bytes_offered = 0;
  logic [7:0] code_buffer[$];

  // Short directed buffers: every form, the special cases and prefix variety.
  x86mov_pkg::in_item_t directed_stream [25] = '{
    {x86mov_pkg::PFX_OP16, 1'b0}, {x86mov_pkg::OP_MOV_REG_RM, 1'b0}, {8'hC8, 1'b1},
    {x86mov_pkg::OP_MOV_RM_REG, 1'b0}, {8'h00, 1'b1},
    {OP_MOV_IMM_EDI, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
    {x86mov_pkg::OP_MOV_REG_RM, 1'b0}, {8'h45, 1'b0}, {8'h80, 1'b1},
    {OP_ESCAPE, 1'b1},
    {x86mov_pkg::OP_MOV_REG_RM, 1'b1},
    {x86mov_pkg::PFX_LOCK, 1'b0}, {x86mov_pkg::PFX_REP, 1'b0}, {x86mov_pkg::PFX_GS, 1'b0},
    {x86mov_pkg::OP_MOV_RM_REG, 1'b0},
    {8'hC0, 1'b0}, {8'h90, 1'b1},
    {x86mov_pkg::PFX_REPNE, 1'b0}, {x86mov_pkg::PFX_ADDR16, 1'b0},
    {x86mov_pkg::OP_MOV_REG_RM, 1'b0}, {8'h3F, 1'b1}
  };

  always #4 clk = ~clk;

  x86_mov_instruction_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  x86mov_decode_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  // Result side: random stalls, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      result_ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any request moving on either channel.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_prefix();
    case ($urandom_range(0, 10))
      0:       return x86mov_pkg::PFX_LOCK;
      1:       return x86mov_pkg::PFX_REPNE;
      2:       return x86mov_pkg::PFX_REP;
      3:       return x86mov_pkg::PFX_ES;
      4:       return x86mov_pkg::PFX_CS;
      5:       return x86mov_pkg::PFX_SS;
      6:       return x86mov_pkg::PFX_DS;
      7:       return x86mov_pkg::PFX_FS;
      8:       return x86mov_pkg::PFX_GS;
      9:       return x86mov_pkg::PFX_OP16;
      default: return x86mov_pkg::PFX_ADDR16;
    endcase
  endfunction

  // Offer one code-byte request, with an optional idle gap first, and wait for acceptance.
  task automatic offer_byte(input x86mov_pkg::in_item_t item);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    do @(posedge clk); while (!byte_ready);
    bytes_offered++;
  endtask

  // Mostly well-formed instructions with random content; some cut short, some noise.
  task automatic build_code_buffer();
    int         kind;
    int         npfx;
    int         pick;
    int         ndata;
    int         cut;
    logic [7:0] modrm;
    code_buffer.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 20)) code_buffer.push_back(random_byte());
    end else begin
      // A few buffers carry enough prefixes to reach or run past the length limit.
      npfx = ($urandom_range(0, 99) < 8) ? $urandom_range(13, 17) : $urandom_range(0, 3);
      repeat (npfx) code_buffer.push_back(pick_prefix());
      pick  = $urandom_range(0, 99);
      ndata = 0;
      modrm = random_byte();
      if (pick < 30) begin
        if ($urandom_range(0, 99) < 80)
          modrm[7:6] = x86mov_pkg::MOD_REG;
        code_buffer.push_back(x86mov_pkg::OP_MOV_RM_REG);
        code_buffer.push_back(modrm);
      end else if (pick < 65) begin
        code_buffer.push_back(x86mov_pkg::OP_MOV_REG_RM);
        code_buffer.push_back(modrm);
        if (modrm[7:6] == x86mov_pkg::MOD_DISP8)
          ndata = 1;
        else if (modrm[7:6] != x86mov_pkg::MOD_REG && modrm[7:6] != x86mov_pkg::MOD_NODISP)
          ndata = 4;
      end else if (pick < 90) begin
        code_buffer.push_back(x86mov_pkg::OP_MOV_IMM | 8'($urandom_range(0, 7)));
        ndata = 4;
      end else begin
        code_buffer.push_back(($urandom_range(0, 99) < 30) ? OP_ESCAPE : random_byte());
      end
      // Data bytes, then a few trailing bytes the decoder must swallow.
      repeat (ndata + $urandom_range(0, 2)) code_buffer.push_back(random_byte());
      if (kind < 30) begin
        cut = $urandom_range(1, code_buffer.size());
        while (code_buffer.size() > cut) void'(code_buffer.pop_back());
      end
    end
  endtask

  // One stimulus phase with the given idle and stall rates.
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int target);
    int start;
    start          = bytes_offered;
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
    while (bytes_offered - start < target) begin
      build_code_buffer();
      foreach (code_buffer[i])
        offer_byte({code_buffer[i], i == code_buffer.size() - 1});
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_stream[i])
      offer_byte(directed_stream[i]);

    run_random_phase(0, 0, 380);
    run_random_phase(73, 0, 380);
    run_random_phase(0, 73, 380);
    run_random_phase(18, 18, 380);

    // Hold the result side off while bytes keep coming, so the input backs up.
    hold_req <= 1'b1;
    run_random_phase(0, 0, 80);
    hold_req <= 1'b0;
    byte_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
design/x86mov_pkg.sv
design/x86mov_in_reg.sv
design/x86mov_decode.sv
design/x86mov_out_reg.sv
design/x86_mov_instruction_decoder.sv
test/x86mov_decode_checker.sv
test/x86_mov_instruction_decoder_tb.sv
